// ===== sv/cccv_pkg.sv =====
// -----------------------------------------------------------------------------
// cccv_pkg
// Types, codes, widths and helpers shared by the charge controller modules.
// -----------------------------------------------------------------------------
package cccv_pkg;

    // field widths
    localparam int VOLT_W      = 16;
    localparam int CURR_W      = 16;
    localparam int NOW_W       = 32;
    localparam int CFG_V_W     = 13;
    localparam int CFG_TENTH_W = 10;
    localparam int CFG_LIM_W   = 14;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 24;

    // default internal time width
    localparam int TIME_WIDTH_DEF = 32;

    // register reset values
    localparam logic [CFG_V_W-1:0]     RST_CHARGE_VOLTAGE = 13'd4800;
    localparam logic [CFG_V_W-1:0]     RST_CHARGE_CURRENT = 13'd6250;
    localparam logic [CFG_V_W-1:0]     RST_RELOAD_VOLTAGE = 13'd4800;
    localparam logic [VOLT_W-1:0]      RST_PRESENCE_THR   = 16'd4320;
    localparam logic [CFG_DATA_W-1:0]  RST_CV_TIMEOUT     = 32'd1800000;

    // ramp step and setpoint limits
    localparam logic [VOLT_W-1:0] RAMP_STEP   = 16'd10;
    localparam logic [VOLT_W-1:0] SP_MAX      = 16'hFFFF;
    localparam logic [VOLT_W-1:0] RAMP_LIMIT  = 16'd65525;

    // reciprocal of ten, scaled by 2^16
    localparam logic [CFG_V_W-1:0] RECIP_TEN = 13'd6554;

    typedef enum logic [2:0] {
        PH_DETECT      = 3'd0,
        PH_RAMP        = 3'd1,
        PH_CC          = 3'd2,
        PH_CV          = 3'd3,
        PH_RELOAD      = 3'd4,
        PH_REMOVAL     = 3'd5,
        PH_OVERCURRENT = 3'd6,
        PH_OPEN        = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHARGE_VOLTAGE = 3'd0,
        CFG_CHARGE_CURRENT = 3'd1,
        CFG_RELOAD_VOLTAGE = 3'd2,
        CFG_CYCLE_MODE     = 3'd3,
        CFG_PRESENCE_THR   = 3'd4,
        CFG_CV_TIMEOUT     = 3'd5,
        CFG_OC_ENABLE      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_V_W-1:0]     charge_voltage;
        logic [CFG_V_W-1:0]     charge_current;
        logic [CFG_TENTH_W-1:0] cc_tenth;       // charge_current / 10
        logic [CFG_LIM_W-1:0]   cc_return;      // floor(1.5 * charge_current)
        logic [CFG_V_W-1:0]     reload_voltage;
        logic                   cycle_mode;
        logic [VOLT_W-1:0]      presence_thr;
        logic [CFG_DATA_W-1:0]  cv_timeout_ms;
        logic                   oc_enable;
    } t_cfg;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage;
        logic [CURR_W-1:0] current;
        logic [NOW_W-1:0]  now_ms;
    } t_item;

    typedef struct packed {
        logic              sp_write;
        logic [VOLT_W-1:0] sp_value;
        t_cmd              cmd;
        t_phase            phase;
    } t_result;

    // floor(x / 10) for 13-bit x, exact over the whole range
    function automatic logic [CFG_TENTH_W-1:0] div10(input logic [CFG_V_W-1:0] x);
        logic [2*CFG_V_W-1:0] prod;
        prod = {{CFG_V_W{1'b0}}, x} * {{CFG_V_W{1'b0}}, RECIP_TEN};
        return prod[16 +: CFG_TENTH_W];
    endfunction

    // floor(1.5 * x) for 13-bit x
    function automatic logic [CFG_LIM_W-1:0] times_1p5(input logic [CFG_V_W-1:0] x);
        logic [CFG_LIM_W:0] sum;
        sum = {2'b00, x} + {1'b0, x, 1'b0};
        return sum[CFG_LIM_W:1];
    endfunction

endpackage

// ===== sv/cccv_cfg.sv =====
// -----------------------------------------------------------------------------
// cccv_cfg
// Configuration register file; also keeps the derived current thresholds.
// -----------------------------------------------------------------------------
module cccv_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [cccv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cccv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output cccv_pkg::t_cfg                  o_cfg
);
    import cccv_pkg::*;

    t_cfg r_cfg;

    // write one register per accepted write; derive thresholds with the current
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.charge_voltage <= RST_CHARGE_VOLTAGE;
            r_cfg.charge_current <= RST_CHARGE_CURRENT;
            r_cfg.cc_tenth       <= div10(RST_CHARGE_CURRENT);
            r_cfg.cc_return      <= times_1p5(RST_CHARGE_CURRENT);
            r_cfg.reload_voltage <= RST_RELOAD_VOLTAGE;
            r_cfg.cycle_mode     <= 1'b0;
            r_cfg.presence_thr   <= RST_PRESENCE_THR;
            r_cfg.cv_timeout_ms  <= RST_CV_TIMEOUT;
            r_cfg.oc_enable      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CHARGE_VOLTAGE: r_cfg.charge_voltage <= i_cfg_data[CFG_V_W-1:0];
                CFG_CHARGE_CURRENT: begin
                    r_cfg.charge_current <= i_cfg_data[CFG_V_W-1:0];
                    r_cfg.cc_tenth       <= div10(i_cfg_data[CFG_V_W-1:0]);
                    r_cfg.cc_return      <= times_1p5(i_cfg_data[CFG_V_W-1:0]);
                end
                CFG_RELOAD_VOLTAGE: r_cfg.reload_voltage <= i_cfg_data[CFG_V_W-1:0];
                CFG_CYCLE_MODE:     r_cfg.cycle_mode     <= i_cfg_data[0];
                CFG_PRESENCE_THR:   r_cfg.presence_thr   <= i_cfg_data[VOLT_W-1:0];
                CFG_CV_TIMEOUT:     r_cfg.cv_timeout_ms  <= i_cfg_data;
                CFG_OC_ENABLE:      r_cfg.oc_enable      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/cccv_phase.sv =====
// -----------------------------------------------------------------------------
// cccv_phase
// Charge phase sequencer: holds the charge state and works out one result.
// -----------------------------------------------------------------------------
module cccv_phase #(
    parameter int TIME_WIDTH = cccv_pkg::TIME_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  cccv_pkg::t_item   i_item,
    input  cccv_pkg::t_cfg    i_cfg,
    output cccv_pkg::t_result o_result
);
    import cccv_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > NOW_W) ? TIME_WIDTH : NOW_W;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [VOLT_W-1:0]     r_setpoint;
    logic [VOLT_W-1:0]     n_setpoint;
    logic [TIME_WIDTH-1:0] r_cv_start;
    logic [TIME_WIDTH-1:0] n_cv_start;
    logic                  r_present;
    logic                  n_present;

    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_elapsed;
    logic                  w_timeout;
    logic                  w_oc;
    logic                  w_above_thr;
    logic                  w_below_thr;
    logic                  w_below_target;
    logic                  w_below_tenth;
    logic                  w_above_return;
    logic                  w_reload;
    logic                  w_curr_zero;
    logic [VOLT_W-1:0]     w_sp_ramp;
    logic [VOLT_W-1:0]     w_sp_cc;
    logic                  w_cv_reached;
    t_phase                w_end_phase;

    // shared compares
    assign w_now          = TIME_WIDTH'(i_item.now_ms);
    assign w_elapsed      = w_now - r_cv_start;
    assign w_timeout      = CMP_W'(w_elapsed) >= CMP_W'(i_cfg.cv_timeout_ms);
    assign w_oc           = i_cfg.oc_enable &&
                            (i_item.current > {2'b00, i_cfg.charge_current, 1'b0});
    assign w_above_thr    = i_item.voltage > i_cfg.presence_thr;
    assign w_below_thr    = i_item.voltage < i_cfg.presence_thr;
    assign w_below_target = i_item.current < {3'b000, i_cfg.charge_current};
    assign w_below_tenth  = i_item.current < {6'd0, i_cfg.cc_tenth};
    assign w_above_return = i_item.current > {2'b00, i_cfg.cc_return};
    assign w_reload       = i_item.voltage <= {3'b000, i_cfg.reload_voltage};
    assign w_curr_zero    = i_item.current == '0;
    assign w_end_phase    = i_cfg.cycle_mode ? PH_RELOAD : PH_REMOVAL;

    // saturating setpoint steps
    assign w_sp_ramp = (r_setpoint > RAMP_LIMIT) ? SP_MAX : r_setpoint + RAMP_STEP;

    always_comb begin
        if (w_below_target) begin
            w_sp_cc = (r_setpoint == SP_MAX) ? r_setpoint : r_setpoint + 16'd1;
        end else begin
            w_sp_cc = (r_setpoint == '0) ? r_setpoint : r_setpoint - 16'd1;
        end
    end

    assign w_cv_reached = w_sp_cc >= {3'b000, i_cfg.charge_voltage};

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_DETECT: begin
                if (w_above_thr && r_present) n_phase = PH_RAMP;
            end
            PH_RAMP: begin
                if (w_oc)                 n_phase = PH_OVERCURRENT;
                else if (!w_below_target) n_phase = PH_CC;
            end
            PH_CC: begin
                if (w_oc)              n_phase = PH_OVERCURRENT;
                else if (w_curr_zero)  n_phase = PH_OPEN;
                else if (w_cv_reached) n_phase = PH_CV;
            end
            PH_CV: begin
                if (w_oc)                n_phase = PH_OVERCURRENT;
                else if (w_below_tenth)  n_phase = w_end_phase;
                else if (w_timeout)      n_phase = w_end_phase;
                else if (w_above_return) n_phase = PH_CC;
            end
            PH_RELOAD: begin
                if (w_reload) n_phase = PH_RAMP;
            end
            PH_REMOVAL: begin
                if (w_below_thr) n_phase = PH_DETECT;
            end
            PH_OVERCURRENT, PH_OPEN: begin
                n_phase = r_phase;
            end
        endcase
    end

    // result fields and datapath state
    always_comb begin
        o_result.sp_write = 1'b0;
        o_result.sp_value = '0;
        o_result.cmd      = CMD_NONE;
        o_result.phase    = n_phase;
        n_setpoint        = r_setpoint;
        n_cv_start        = r_cv_start;
        n_present         = r_present;
        unique case (r_phase)
            PH_DETECT: begin
                if (w_above_thr) begin
                    n_present = !r_present;
                    if (r_present) begin
                        n_setpoint        = i_item.voltage;
                        o_result.sp_write = 1'b1;
                        o_result.sp_value = i_item.voltage;
                        o_result.cmd      = CMD_ON;
                    end
                end else begin
                    n_present = 1'b0;
                end
            end
            PH_RAMP: begin
                if (w_oc) begin
                    o_result.cmd = CMD_OFF;
                end else if (w_below_target) begin
                    n_setpoint        = w_sp_ramp;
                    o_result.sp_write = 1'b1;
                    o_result.sp_value = w_sp_ramp;
                end
            end
            PH_CC: begin
                if (w_oc || w_curr_zero) begin
                    o_result.cmd = CMD_OFF;
                end else begin
                    n_setpoint        = w_sp_cc;
                    o_result.sp_write = 1'b1;
                    if (w_cv_reached) begin
                        o_result.sp_value = {3'b000, i_cfg.charge_voltage};
                        n_cv_start        = w_now;
                    end else begin
                        o_result.sp_value = w_sp_cc;
                    end
                end
            end
            PH_CV: begin
                if (w_oc || w_below_tenth || w_timeout) o_result.cmd = CMD_OFF;
            end
            PH_RELOAD: begin
                if (w_reload) begin
                    n_setpoint        = i_item.voltage;
                    o_result.sp_write = 1'b1;
                    o_result.sp_value = i_item.voltage;
                    o_result.cmd      = CMD_ON;
                end
            end
            PH_REMOVAL: begin
                if (w_below_thr) n_present = 1'b0;
            end
            PH_OVERCURRENT, PH_OPEN: begin
                n_present = r_present;
            end
        endcase
    end

    // advance state once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DETECT;
            r_setpoint <= '0;
            r_cv_start <= '0;
            r_present  <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_setpoint <= n_setpoint;
            r_cv_start <= n_cv_start;
            r_present  <= n_present;
        end
    end

`ifndef ASSERT_OFF
    // error phases hold until reset
    a_err_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OVERCURRENT || r_phase == PH_OPEN) |=> $stable(r_phase))
        else $error("error phase left without reset");

    // turning the supply on always starts a ramp
    a_on_to_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.cmd == CMD_ON) |=> r_phase == PH_RAMP)
        else $error("supply on without entering ramp");

    // turning the supply off always ends the charge
    a_off_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.cmd == CMD_OFF) |=>
        (r_phase != PH_RAMP && r_phase != PH_CC && r_phase != PH_CV))
        else $error("supply off while still charging");
`endif

endmodule

// ===== sv/cc_cv_battery_charge_controller.sv =====
// Path: an accepted item waits in the input register and moves into the output
// register once that register is free or draining, and is offered from there.
// Throughput: one item per cycle unless stalled, set by the single register pass.
// Reset: synchronous active-low i_rst_n clears both stages, the phase state and
// the configuration registers to their documented defaults.
// -----------------------------------------------------------------------------
// cc_cv_battery_charge_controller
// CC/CV charge sequencer on measurement items, with a register write channel.
// -----------------------------------------------------------------------------
module cc_cv_battery_charge_controller #(
    parameter int TIME_WIDTH = cccv_pkg::TIME_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] measured_voltage, [31:16] measured_current, [63:32] now_ms
    input  logic [cccv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] setpoint_write, [16:1] setpoint_value, [18:17] supply_command,
    // [21:19] phase_code, [23:22] zero
    output logic [cccv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cccv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cccv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cccv_pkg::*;

    logic    r_in_vld;
    t_item   r_in_item;
    logic    r_out_vld;
    t_result r_out_res;
    logic    w_step;
    t_result w_result;
    t_cfg    w_cfg;

    // process the held item when the result register is free or draining
    assign w_step        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_step;
    assign o_cfg_ready   = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.voltage <= s_axis_tdata[15:0];
            r_in_item.current <= s_axis_tdata[31:16];
            r_in_item.now_ms  <= s_axis_tdata[63:32];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_res <= w_result;
        end
    end

    cccv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    cccv_phase #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // pack the result item
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_res.phase, r_out_res.cmd,
                            r_out_res.sp_value, r_out_res.sp_write};

endmodule
